@@ src/pali_pkg.sv @@
package pali_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int CNT_W        = PT_AW + 1;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;

  localparam logic [47:0] LEN_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] DEG360   = 34'd23592960;
  localparam logic signed [31:0] DEG180 = 32'sd11796480;
  localparam logic signed [31:0] DEG90  = 32'sd5898240;
  // Offset that lifts any signed 32-bit heading to a non-negative value.
  localparam logic [33:0] MOD_BIAS = 34'd2170552320;
  localparam logic signed [39:0] SIX_GAIN_Q30 = 40'sd3912197244;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PRD, S_PCAP, S_PSQ, S_PRT, S_PWR,
    S_QRT, S_QCAP, S_QMUL, S_QSR, S_QSC, S_QRA, S_QRB,
    S_QDC, S_QDV, S_QLM, S_QLA, S_QCS, S_QCW, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    C_IDLE, C_MOD, C_FOLD, C_ITER, C_DONE
  } cordic_state_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] sin6;
    logic signed [31:0] cos6;
  } sincos_t;

  function automatic logic signed [31:0] atan_deg(input logic [STEP_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/pali_cordic.sv @@
module pali_cordic import pali_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] heading,
  output sincos_t            res
);

  cordic_state_t state_r, state_nxt;
  logic [33:0]        u_r;
  logic [3:0]         k_r;
  logic [STEP_W-1:0]  i_r;
  logic signed [39:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic               neg_r;

  logic [33:0]        dk;
  logic signed [31:0] zf, zw;
  logic signed [39:0] xs, ys, xo, yo, sr, cr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_MOD;
      C_MOD:  if (k_r == 4'd0) state_nxt = C_FOLD;
      C_FOLD: state_nxt = C_ITER;
      C_ITER: if (i_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = C_DONE;
      C_DONE: state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  assign dk = DEG360 << k_r;
  assign zw = (signed'(u_r[31:0]) > DEG180) ? signed'(u_r[31:0]) - 32'(DEG360)
                                            : signed'(u_r[31:0]);
  assign zf = (zw > DEG90) ? zw - DEG180 : ((zw < -DEG90) ? zw + DEG180 : zw);
  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      C_IDLE: begin
        u_r <= 34'(signed'(heading)) + MOD_BIAS;
        k_r <= 4'd8;
      end
      C_MOD: begin
        if (u_r >= dk) u_r <= u_r - dk;
        k_r <= k_r - 4'd1;
      end
      C_FOLD: begin
        z_r   <= zf;
        neg_r <= (zw > DEG90) || (zw < -DEG90);
        x_r   <= SIX_GAIN_Q30;
        y_r   <= '0;
        i_r   <= '0;
      end
      C_ITER: begin
        if (z_r >= 0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_deg(i_r);
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_deg(i_r);
        end
        i_r <= i_r + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // Rounding to Q16.16 with halves going up.
  assign xo = neg_r ? -x_r : x_r;
  assign yo = neg_r ? -y_r : y_r;
  assign sr = (yo + 40'sd8192) >>> 14;
  assign cr = (xo + 40'sd8192) >>> 14;

  assign res.valid = (state_r == C_DONE);
  assign res.sin6  = sr[31:0];
  assign res.cos6  = cr[31:0];

endmodule

@@ src/polyline_arc_length_interpolator.sv @@
// Polyline arc-length interpolator.
// The input channel (in_valid/in_ready) carries one item per operation:
// push a track point, query a position along the track, or clear the track.
// Every item gives exactly one result item on the out_ channel: a status
// and, for a successful query, the spot, the camera 6 units behind it along
// the heading and the look vector; all other fields are zero.
// Items are worked one at a time by a sequencer around four point tables
// (x, y, heading, cumulative length) held in synchronous memories.
// A push forms the sum of squares (shift-add) and the bit-pair square
// root of the step from the last point; the first push skips both.
// A query runs the length product, a scan over the table entries, the
// restoring divider when it runs, the three interpolations and range
// reduction and CORDIC. Errors and clear skip all of these steps.
// A finished result sits in the output register until taken; the block
// accepts the next item meanwhile and only waits at the end of that item
// if the register is still full. After reset the track is empty; the
// tables need no clearing pass since only pushed entries are read.
module polyline_arc_length_interpolator import pali_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_new_x,
  input  logic signed [31:0] in_new_y,
  input  logic signed [31:0] in_new_heading,
  input  logic [15:0]        in_fraction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_spot_x,
  output logic signed [31:0] out_spot_y,
  output logic signed [31:0] out_camera_x,
  output logic signed [31:0] out_camera_y,
  output logic signed [31:0] out_look_x,
  output logic signed [31:0] out_look_y
);

  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] h_mem [MAX_POINTS];
  logic [47:0]        c_mem [MAX_POINTS];

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   cnt_r;
  logic [PT_AW-1:0]   idx_r;
  logic [5:0]         k_r;
  logic [1:0]         lc_r;
  status_t            status_r;
  logic               query_r;
  logic signed [31:0] nx_r, ny_r, nh_r;
  logic [15:0]        fr_r;
  logic [65:0]        acc_r;
  logic [31:0]        ua_r, ub_r;
  logic [63:0]        ma_r, mb_r;
  logic [32:0]        root_r;
  logic [34:0]        rem_r;
  logic [63:0]        tgt_r, tot_r, num_r, dv_r;
  logic [47:0]        ca_r, cb_r, seg_r;
  logic signed [31:0] xa_r, xb_r, ya_r, yb_r, ha_r, hb_r;
  logic [16:0]        q_r, t_r;
  logic signed [50:0] prod_r;
  logic signed [31:0] sx_r, sy_r, hd_r, s6_r, c6_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_sx_r, out_sy_r, out_cx_r, out_cy_r, out_lx_r, out_ly_r;

  logic [PT_AW-1:0]   rd_addr;
  logic signed [31:0] rd_x, rd_y, rd_h;
  logic [47:0]        rd_c;
  logic               wr_en;

  logic               in_acc, out_free, search_more;
  logic [CNT_W-1:0]   last_cnt;
  logic [32:0]        dx, dy;
  logic [36:0]        rem_t, trial;
  logic [48:0]        cum_sum;
  logic [47:0]        cum_new;
  logic [64:0]        seg_top;
  logic               qbit;
  logic [16:0]        q_fin;
  logic signed [31:0] la, lb;
  logic signed [32:0] ldiff;
  logic signed [50:0] lsum;
  logic signed [31:0] lres;
  logic signed [32:0] cxd, cyd;
  logic signed [31:0] cx, cy;
  logic               cs_start;
  sincos_t            cs;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign last_cnt = cnt_r - CNT_W'(1);
  assign search_more = ({1'b0, idx_r} < last_cnt) && (tgt_r > {rd_c, 16'b0});

  // Table memories, one read port each, read data registered.
  always_comb begin
    unique case (state_r)
      S_PRD, S_QRT: rd_addr = last_cnt[PT_AW-1:0];
      S_QRA:        rd_addr = idx_r - PT_AW'(1);
      default:      rd_addr = idx_r;
    endcase
  end

  assign wr_en = (state_r == S_PWR);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[cnt_r[PT_AW-1:0]] <= nx_r;
      y_mem[cnt_r[PT_AW-1:0]] <= ny_r;
      h_mem[cnt_r[PT_AW-1:0]] <= nh_r;
      c_mem[cnt_r[PT_AW-1:0]] <= cum_new;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
    rd_h <= h_mem[rd_addr];
    rd_c <= c_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_operation))
            OP_PUSH: begin
              if (cnt_r == CNT_W'(MAX_POINTS)) state_nxt = S_FIN;
              else if (cnt_r == '0)           state_nxt = S_PWR;
              else                            state_nxt = S_PRD;
            end
            OP_QUERY: begin
              if (in_fraction == '0 || cnt_r < CNT_W'(2)) state_nxt = S_FIN;
              else                                       state_nxt = S_QRT;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_PRD:  state_nxt = S_PCAP;
      S_PCAP: state_nxt = S_PSQ;
      S_PSQ:  if (k_r == 6'd31) state_nxt = S_PRT;
      S_PRT:  if (k_r == 6'd0) state_nxt = S_PWR;
      S_PWR:  state_nxt = S_FIN;
      S_QRT:  state_nxt = S_QCAP;
      S_QCAP: state_nxt = S_QMUL;
      S_QMUL: if (k_r == 6'd15) state_nxt = S_QSR;
      S_QSR:  state_nxt = S_QSC;
      S_QSC:  state_nxt = search_more ? S_QSR : S_QRA;
      S_QRA:  state_nxt = S_QRB;
      S_QRB:  state_nxt = S_QDC;
      S_QDC: begin
        if (seg_r == '0 || num_r >= seg_top[63:0] && seg_top[64] == 1'b0)
          state_nxt = S_QLM;
        else if (seg_top[64] == 1'b0 && num_r >= seg_top[63:0])
          state_nxt = S_QLM;
        else
          state_nxt = S_QDV;
      end
      S_QDV:  if (k_r == 6'd0) state_nxt = S_QLM;
      S_QLM:  state_nxt = S_QLA;
      S_QLA:  state_nxt = (lc_r == 2'd2) ? S_QCS : S_QLM;
      S_QCS:  state_nxt = S_QCW;
      S_QCW:  if (cs.valid) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath helpers.
  assign dx = {nx_r[31], nx_r} - {rd_x[31], rd_x};
  assign dy = {ny_r[31], ny_r} - {rd_y[31], rd_y};
  assign rem_t = {rem_r, acc_r[65:64]};
  assign trial = {2'b0, root_r, 2'b01};
  assign cum_sum = {1'b0, ca_r} + 49'(root_r);
  assign cum_new = (cnt_r == '0) ? 48'd0 : (cum_sum[48] ? LEN_MAX : cum_sum[47:0]);
  assign seg_top = {seg_r, 17'b0};
  assign qbit  = (num_r >= dv_r);
  assign q_fin = {q_r[15:0], qbit};

  always_comb begin
    unique case (lc_r)
      2'd0:    begin la = xa_r; lb = xb_r; end
      2'd1:    begin la = ya_r; lb = yb_r; end
      default: begin la = ha_r; lb = hb_r; end
    endcase
  end
  assign ldiff = 33'(lb) - 33'(la);
  assign lsum  = (prod_r + 51'sd32768) >>> 16;
  assign lres  = la + lsum[31:0];

  assign cs_start = (state_r == S_QCS);

  pali_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cs_start),
    .heading (hd_r),
    .res     (cs)
  );

  assign cxd = 33'(sx_r) - 33'(s6_r);
  assign cyd = 33'(sy_r) - 33'(c6_r);
  assign cx  = (cxd > 33'sd2147483647) ? 32'sh7FFF_FFFF :
               (cxd < -33'sd2147483648) ? 32'sh8000_0000 : cxd[31:0];
  assign cy  = (cyd > 33'sd2147483647) ? 32'sh7FFF_FFFF :
               (cyd < -33'sd2147483648) ? 32'sh8000_0000 : cyd[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && op_t'(in_operation) == OP_CLEAR) begin
      cnt_r <= '0;
    end else if (wr_en) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // The query flag is kept from acceptance to the end of the item.
  always_ff @(posedge clk) begin
    if (in_acc) query_r <= (op_t'(in_operation) == OP_QUERY);
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          nx_r <= in_new_x;
          ny_r <= in_new_y;
          nh_r <= in_new_heading;
          fr_r <= in_fraction;
          if (op_t'(in_operation) == OP_PUSH && cnt_r == CNT_W'(MAX_POINTS))
            status_r <= ST_FULL;
          else if (op_t'(in_operation) == OP_QUERY && in_fraction == '0)
            status_r <= ST_RANGE;
          else if (op_t'(in_operation) == OP_QUERY && cnt_r < CNT_W'(2))
            status_r <= ST_FEW;
          else
            status_r <= ST_OK;
        end
      end
      S_PCAP: begin
        ua_r <= dx[32] ? 32'(-dx) : dx[31:0];
        ub_r <= dy[32] ? 32'(-dy) : dy[31:0];
        ma_r <= 64'(dx[32] ? 32'(-dx) : dx[31:0]);
        mb_r <= 64'(dy[32] ? 32'(-dy) : dy[31:0]);
        ca_r <= rd_c;
        acc_r <= '0;
        k_r <= '0;
      end
      S_PSQ: begin
        acc_r <= acc_r + 66'(ua_r[0] ? ma_r : 64'd0) + 66'(ub_r[0] ? mb_r : 64'd0);
        ua_r <= ua_r >> 1;
        ub_r <= ub_r >> 1;
        ma_r <= ma_r << 1;
        mb_r <= mb_r << 1;
        k_r <= k_r + 6'd1;
        root_r <= '0;
        rem_r <= '0;
      end
      S_PRT: begin
        // One result bit per cycle, taking the radicand two bits at a time.
        if (rem_t >= trial) begin
          rem_r  <= 35'(rem_t - trial);
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= rem_t[34:0];
          root_r <= {root_r[31:0], 1'b0};
        end
        acc_r <= acc_r << 2;
        k_r <= k_r - 6'd1;
      end
      S_QCAP: begin
        tot_r <= 64'(rd_c);
        tgt_r <= '0;
        k_r <= '0;
      end
      S_QMUL: begin
        tgt_r <= tgt_r + (fr_r[0] ? tot_r : 64'd0);
        fr_r <= fr_r >> 1;
        tot_r <= tot_r << 1;
        k_r <= k_r + 6'd1;
        idx_r <= PT_AW'(1);
      end
      S_QSC: begin
        if (search_more) begin
          idx_r <= idx_r + PT_AW'(1);
        end else begin
          cb_r <= rd_c;
          xb_r <= rd_x;
          yb_r <= rd_y;
          hb_r <= rd_h;
        end
      end
      S_QRB: begin
        num_r <= (tgt_r >= {rd_c, 16'b0}) ? tgt_r - {rd_c, 16'b0} : 64'd0;
        seg_r <= cb_r - rd_c;
        xa_r <= rd_x;
        ya_r <= rd_y;
        ha_r <= rd_h;
      end
      S_QDC: begin
        dv_r <= {seg_r, 16'b0};
        q_r  <= '0;
        k_r  <= 6'd16;
        lc_r <= '0;
        if (seg_r == '0)
          t_r <= '0;
        else
          t_r <= 17'd65536;
      end
      S_QDV: begin
        if (qbit) num_r <= num_r - dv_r;
        dv_r <= dv_r >> 1;
        q_r  <= q_fin;
        k_r  <= k_r - 6'd1;
        if (k_r == 6'd0) t_r <= (q_fin > 17'd65536) ? 17'd65536 : q_fin;
      end
      S_QLM: prod_r <= signed'({1'b0, t_r}) * ldiff;
      S_QLA: begin
        unique case (lc_r)
          2'd0:    sx_r <= lres;
          2'd1:    sy_r <= lres;
          default: hd_r <= lres;
        endcase
        lc_r <= lc_r + 2'd1;
      end
      S_QCW: begin
        if (cs.valid) begin
          s6_r <= cs.sin6;
          c6_r <= cs.cos6;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_status_r <= status_r;
      if (status_r == ST_OK && query_r) begin
        out_sx_r <= sx_r;
        out_sy_r <= sy_r;
        out_cx_r <= cx;
        out_cy_r <= cy;
        out_lx_r <= sx_r - cx;
        out_ly_r <= sy_r - cy;
      end else begin
        out_sx_r <= '0;
        out_sy_r <= '0;
        out_cx_r <= '0;
        out_cy_r <= '0;
        out_lx_r <= '0;
        out_ly_r <= '0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_spot_x   = out_sx_r;
  assign out_spot_y   = out_sy_r;
  assign out_camera_x = out_cx_r;
  assign out_camera_y = out_cy_r;
  assign out_look_x   = out_lx_r;
  assign out_look_y   = out_ly_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_search_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_QSC |-> idx_r != '0 && {1'b0, idx_r} < cnt_r)
    else $error("segment search index outside the track");

  a_look_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_look_x == out_spot_x - out_camera_x)
    else $error("look vector does not match spot and camera");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_spot_x == '0 && out_camera_y == '0)
    else $error("fields not cleared on error status");

endmodule
